### design/split_screen_tile_layout_assert.svh
// ----------------------------------------------------------------------------
// Split-screen tile layout assertion macros
// Shared concurrent assertion forms used by the tile layout RTL.
// ----------------------------------------------------------------------------
`ifndef SPLIT_SCREEN_TILE_LAYOUT_ASSERT_SVH
`define SPLIT_SCREEN_TILE_LAYOUT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SSTL_ASSERT_IMPL(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
		else $error("tile layout same-cycle check failed");

// next-cycle implication, checked out of reset
`define SSTL_ASSERT_NEXT(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
		else $error("tile layout next-cycle check failed");

`endif

### design/sstl_pkg.sv
// ----------------------------------------------------------------------------
// Split-screen tile layout package
// Widths, defaults and sequencer states shared by the layout modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sstl_pkg;

	localparam int MAX_TILES_DEF = 16;
	localparam int XY_W          = 16;
	localparam int TILE_XY_W     = 17;
	localparam int POS_W         = 18;
	localparam int DIM_W         = 15;
	localparam int VC_W          = 5;
	localparam int IDX_W         = 4;
	// column and row counts stay at or below 8 for up to 64 tiles
	localparam int N_W           = 4;
	localparam int CMP_W         = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_DIVW,
		ST_DIVH,
		ST_PREP,
		ST_LOAD,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

### design/sstl_div.sv
// ----------------------------------------------------------------------------
// Split-screen tile layout divider
// Restoring divider, one quotient bit per cycle, shared by both tile sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module sstl_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [sstl_pkg::DIM_W-1:0] dividend,
	input  wire logic [sstl_pkg::N_W-1:0]   divisor,
	output logic                            done,
	output logic [sstl_pkg::DIM_W-1:0]      quotient
);
	import sstl_pkg::*;

	localparam int STEP_W = $clog2(DIM_W);

	logic              running_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [N_W-1:0]    dvs_q;
	logic [N_W-1:0]    rem_q;
	logic [DIM_W-1:0]  quo_q;
	logic [N_W:0]      trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
		end else begin
			done_q <= running_q && (step_q == '0);
			if (go) begin
				running_q <= 1'b1;
				step_q    <= STEP_W'(DIM_W - 1);
			end else if (running_q) begin
				if (step_q == '0) begin
					running_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// shift dividend bits out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (go) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (running_q) begin
			if (fits) begin
				rem_q <= N_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[N_W-1:0];
			end
			quo_q <= {quo_q[DIM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### design/split_screen_tile_layout.sv
// ----------------------------------------------------------------------------
// Split-screen tile layout
// Splits a main rectangle into up to MAX_TILES tiles and emits them in order.
// ----------------------------------------------------------------------------
// Busy while it runs the column search, the shared divider for tile width
// and then tile height, and the setup states ST_PREP and ST_LOAD, then
// emits one tile a cycle on tile_valid; the receiver cannot stall.
// Reset clears the sequencer and the strobe; the next command is taken at
// the edge that ends the last tile's cycle.
`default_nettype none

`include "split_screen_tile_layout_assert.svh"

module split_screen_tile_layout #(
	parameter int MAX_TILES = sstl_pkg::MAX_TILES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [sstl_pkg::XY_W-1:0]      vp_x,
	input  wire logic signed [sstl_pkg::XY_W-1:0]      vp_y,
	input  wire logic [sstl_pkg::DIM_W-1:0]            vp_width,
	input  wire logic [sstl_pkg::DIM_W-1:0]            vp_height,
	input  wire logic [sstl_pkg::VC_W-1:0]             viewport_count,
	output logic                                       tile_valid,
	output logic signed [sstl_pkg::TILE_XY_W-1:0]      tile_x,
	output logic signed [sstl_pkg::TILE_XY_W-1:0]      tile_y,
	output logic [sstl_pkg::DIM_W-1:0]                 tile_width,
	output logic [sstl_pkg::DIM_W-1:0]                 tile_height,
	output logic [sstl_pkg::IDX_W-1:0]                 tile_index,
	output logic                                       last_tile
);
	import sstl_pkg::*;

	localparam int CNT_W  = $clog2(MAX_TILES + 1);
	localparam int PROD_W = DIM_W + N_W;

	state_t state_q, state_d;

	logic signed [XY_W-1:0] x_q, y_q;
	logic [DIM_W-1:0]       w_q, h_q;
	logic [CNT_W-1:0]       count_q;
	logic [N_W-1:0]         n_q, ncol_q, rows_q, lastlen_q;
	logic                   extra_nz_q;
	logic [DIM_W-1:0]       pw_q, ph_q, slide_q;
	logic signed [POS_W-1:0] xacc_q, ty_q;
	logic [N_W-1:0]         row_q, col_q;
	logic [CNT_W-1:0]       k_q;

	logic                        valid_q;
	logic signed [TILE_XY_W-1:0] tile_x_q, tile_y_q;
	logic [DIM_W-1:0]            tile_w_q, tile_h_q;
	logic [IDX_W-1:0]            tile_idx_q;
	logic                        last_q;

	logic             accept;
	logic [CMP_W-1:0] vc_ext, cnt_sat, cnt8, nsq, extra, rem8;
	logic             few_tiles, root_done, ext_rows;
	logic [N_W-1:0]   ncol_d, rows_d, lastlen_d;
	logic             extra_nz_d;

	logic             div_go, div_done;
	logic [DIM_W-1:0] div_dividend, div_quot;
	logic [N_W-1:0]   div_divisor;

	logic [PROD_W-1:0] row_prod, ty_off;
	logic [DIM_W-1:0]  slide_d;
	logic signed [POS_W-1:0] xbase;

	logic [N_W-1:0] len;
	logic           last_row, end_row, next_last;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = state_q != ST_IDLE;

	// saturate the count, zero reads as one
	always_comb begin
		vc_ext = CMP_W'(viewport_count);
		if (vc_ext == '0) begin
			cnt_sat = CMP_W'(1);
		end else if (vc_ext > CMP_W'(MAX_TILES)) begin
			cnt_sat = CMP_W'(MAX_TILES);
		end else begin
			cnt_sat = vc_ext;
		end
	end

	// column search: smallest n with n*n covering the count, one column for counts up to two
	always_comb begin
		cnt8      = CMP_W'(count_q);
		nsq       = CMP_W'(n_q) * CMP_W'(n_q);
		few_tiles = cnt8 <= CMP_W'(2);
		root_done = few_tiles || (nsq >= cnt8);
		extra     = nsq - cnt8;
		ext_rows  = extra >= CMP_W'(n_q);
		rem8      = ext_rows ? (extra - CMP_W'(n_q)) : extra;
		if (few_tiles) begin
			ncol_d     = N_W'(1);
			rows_d     = N_W'(cnt8);
			lastlen_d  = N_W'(1);
			extra_nz_d = 1'b0;
		end else begin
			ncol_d     = n_q;
			rows_d     = n_q - N_W'(ext_rows);
			lastlen_d  = n_q - N_W'(rem8);
			extra_nz_d = extra != '0;
		end
	end

	assign div_dividend = (state_q == ST_ROOT) ? w_q : h_q;
	assign div_divisor  = (state_q == ST_ROOT) ? ncol_d : rows_q;

	sstl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// slide of the short last row and the top row's bottom edge
	assign row_prod = PROD_W'(lastlen_q) * PROD_W'(pw_q);
	assign ty_off   = PROD_W'(ph_q) * PROD_W'(rows_q - N_W'(1));
	assign slide_d  = extra_nz_q ? ((w_q >> 1) - DIM_W'(row_prod >> 1)) : '0;
	assign xbase    = POS_W'(x_q);

	always_comb begin
		last_row  = row_q == (rows_q - N_W'(1));
		len       = last_row ? lastlen_q : ncol_q;
		end_row   = (col_q + N_W'(1)) == len;
		next_last = (row_q + N_W'(1)) == (rows_q - N_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_go  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_done) begin
					div_go  = 1'b1;
					state_d = ST_DIVW;
				end
			end
			ST_DIVW: begin
				if (div_done) begin
					div_go  = 1'b1;
					state_d = ST_DIVH;
				end
			end
			ST_DIVH: begin
				if (div_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (last_row && end_row) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer counters and the strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			n_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			k_q     <= '0;
		end else begin
			valid_q <= state_q == ST_EMIT;
			case (state_q)
				ST_IDLE: n_q <= N_W'(1);
				ST_ROOT: begin
					if (!root_done) begin
						n_q <= n_q + N_W'(1);
					end
				end
				ST_LOAD: begin
					row_q <= '0;
					col_q <= '0;
					k_q   <= '0;
				end
				ST_EMIT: begin
					k_q <= k_q + CNT_W'(1);
					if (end_row) begin
						row_q <= row_q + N_W'(1);
						col_q <= '0;
					end else begin
						col_q <= col_q + N_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= vp_x;
			y_q     <= vp_y;
			w_q     <= vp_width;
			h_q     <= vp_height;
			count_q <= CNT_W'(cnt_sat);
		end
		case (state_q)
			ST_ROOT: begin
				if (root_done) begin
					ncol_q     <= ncol_d;
					rows_q     <= rows_d;
					lastlen_q  <= lastlen_d;
					extra_nz_q <= extra_nz_d;
				end
			end
			ST_DIVW: begin
				if (div_done) begin
					pw_q <= div_quot;
				end
			end
			ST_DIVH: begin
				if (div_done) begin
					ph_q <= div_quot;
				end
			end
			ST_PREP: begin
				slide_q <= slide_d;
				ty_q    <= POS_W'(y_q) + $signed(POS_W'(ty_off[DIM_W-1:0]));
			end
			ST_LOAD: begin
				xacc_q <= xbase + $signed(POS_W'((rows_q == N_W'(1)) ? slide_q : '0));
			end
			ST_EMIT: begin
				tile_x_q   <= xacc_q[TILE_XY_W-1:0];
				tile_y_q   <= ty_q[TILE_XY_W-1:0];
				tile_w_q   <= pw_q;
				tile_h_q   <= ph_q;
				tile_idx_q <= IDX_W'(k_q);
				last_q     <= last_row && end_row;
				if (end_row) begin
					// drop to the next row, slide it if it is the short one
					ty_q   <= ty_q - $signed(POS_W'(ph_q));
					xacc_q <= xbase + $signed(POS_W'(next_last ? slide_q : '0));
				end else begin
					xacc_q <= xacc_q + $signed(POS_W'(pw_q));
				end
			end
			default: ;
		endcase
	end

	assign tile_valid  = valid_q;
	assign tile_x      = tile_x_q;
	assign tile_y      = tile_y_q;
	assign tile_width  = tile_w_q;
	assign tile_height = tile_h_q;
	assign tile_index  = tile_idx_q;
	assign last_tile   = last_q;

	`SSTL_ASSERT_IMPL(a_word_from_emit, clk, arst_n, valid_q, $past(state_q) == ST_EMIT)
	`SSTL_ASSERT_IMPL(a_last_frees, clk, arst_n, valid_q && last_q, state_q == ST_IDLE)
	`SSTL_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy && !valid_q)

endmodule

`default_nettype wire

### tb/tb_split_screen_tile_layout.sv
// ----------------------------------------------------------------------------
// Split-screen tile layout testbench
// Sends layout requests through the start/busy handshake and checks every
// tile on tile_valid against a layout predictor. A directed table covers
// counts of zero to seventeen and thirty-one, odd heights, zero sizes and coordinate wrap;
// random requests follow, with random sender gaps and drain pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_split_screen_tile_layout;

	import sstl_pkg::*;

	localparam int MAX_TILES      = MAX_TILES_DEF;
	localparam int RANDOM_REQS    = 156;
	localparam int DIRECTED_ROWS  = 24;
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic signed [TILE_XY_W-1:0] x;
		logic signed [TILE_XY_W-1:0] y;
		logic [DIM_W-1:0]            w;
		logic [DIM_W-1:0]            h;
		logic [IDX_W-1:0]            idx;
		logic                        last;
	} tile_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [DIM_W-1:0]       w;
		logic [DIM_W-1:0]       h;
		logic [VC_W-1:0]        vc;
		logic                   has_want;
		tile_t                  want;
	} request_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [XY_W-1:0]      vp_x = '0;
	logic signed [XY_W-1:0]      vp_y = '0;
	logic [DIM_W-1:0]            vp_width = '0;
	logic [DIM_W-1:0]            vp_height = '0;
	logic [VC_W-1:0]             viewport_count = '0;
	logic                        tile_valid;
	logic signed [TILE_XY_W-1:0] tile_x;
	logic signed [TILE_XY_W-1:0] tile_y;
	logic [DIM_W-1:0]            tile_width;
	logic [DIM_W-1:0]            tile_height;
	logic [IDX_W-1:0]            tile_index;
	logic                        last_tile;

	tile_t tiles_due [$];
	int    fail_cnt = 0;
	int    idle_cycles = 0;
	logic  want_pending = 1'b0;
	tile_t want_tile = '0;
	tile_t seen_tile;
	tile_t due_tile;

	// single-tile rows carry their tile written out by hand
	request_t plan [DIRECTED_ROWS] = '{
		'{16'sd0, 16'sd0, 15'd0, 15'd0, 5'd1, 1'b1,
			'{17'sd0, 17'sd0, 15'd0, 15'd0, 4'd0, 1'b1}},
		'{16'sh8000, 16'sh8000, 15'd32767, 15'd32767, 5'd1, 1'b1,
			'{-17'sd32768, -17'sd32768, 15'd32767, 15'd32767, 4'd0, 1'b1}},
		// count of zero behaves as one
		'{16'sd32767, 16'sd32767, 15'd32767, 15'd32767, 5'd0, 1'b1,
			'{17'sd32767, 17'sd32767, 15'd32767, 15'd32767, 4'd0, 1'b1}},
		// two halves, odd height leaves a row uncovered
		'{16'sd10, -16'sd5, 15'd100, 15'd101, 5'd2, 1'b0, '0},
		'{16'sh8000, 16'sd32767, 15'd32767, 15'd0, 5'd2, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd1920, 15'd1080, 5'd3, 1'b0, '0},
		'{16'sd100, 16'sd200, 15'd1920, 15'd1080, 5'd4, 1'b0, '0},
		'{-16'sd50, -16'sd60, 15'd1000, 15'd999, 5'd5, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd640, 15'd480, 5'd6, 1'b0, '0},
		'{16'sd7, 16'sd7, 15'd1280, 15'd720, 5'd7, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd800, 15'd600, 5'd8, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd900, 15'd900, 5'd9, 1'b0, '0},
		'{-16'sd1, -16'sd1, 15'd1001, 15'd777, 5'd10, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd32767, 15'd32767, 5'd11, 1'b0, '0},
		'{16'sd3, 16'sd4, 15'd333, 15'd444, 5'd12, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd1920, 15'd1080, 5'd13, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd1234, 15'd567, 5'd14, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd2000, 15'd1000, 5'd15, 1'b0, '0},
		// full grid at the top corner: tile_x runs past 16 bits signed
		'{16'sd32767, 16'sd32767, 15'd32767, 15'd32767, 5'd16, 1'b0, '0},
		'{16'sh8000, 16'sh8000, 15'd32767, 15'd32767, 5'd16, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd1, 15'd1, 5'd7, 1'b0, '0},
		// counts above the maximum saturate
		'{16'sd0, 16'sd0, 15'd5000, 15'd5000, 5'd17, 1'b0, '0},
		'{16'sd11, 16'sd22, 15'd3000, 15'd2000, 5'd31, 1'b0, '0},
		'{16'sd0, 16'sd0, 15'd0, 15'd0, 5'd16, 1'b0, '0}
	};

	split_screen_tile_layout #(
		.MAX_TILES(MAX_TILES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.vp_x(vp_x),
		.vp_y(vp_y),
		.vp_width(vp_width),
		.vp_height(vp_height),
		.viewport_count(viewport_count),
		.tile_valid(tile_valid),
		.tile_x(tile_x),
		.tile_y(tile_y),
		.tile_width(tile_width),
		.tile_height(tile_height),
		.tile_index(tile_index),
		.last_tile(last_tile)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	function automatic void queue_tile(input int x, input int y, input int w, input int h,
			input int k, input bit last);
		tile_t t;
		t.x = x[TILE_XY_W-1:0];
		t.y = y[TILE_XY_W-1:0];
		t.w = w[DIM_W-1:0];
		t.h = h[DIM_W-1:0];
		t.idx = k[IDX_W-1:0];
		t.last = last;
		tiles_due = {tiles_due, t};
	endfunction

	function automatic void layout_tiles(input logic signed [XY_W-1:0] ox,
			input logic signed [XY_W-1:0] oy, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic [VC_W-1:0] vc);
		int left, bottom, wd, ht, cnt;
		int n, extra, extra_rows, rows, last_len, pw, ph, slide, len, sx, k;
		left = int'(ox);
		bottom = int'(oy);
		wd = int'(w);
		ht = int'(h);
		cnt = int'(vc);
		if (cnt == 0)
			cnt = 1;
		if (cnt > MAX_TILES)
			cnt = MAX_TILES;
		if (cnt == 1) begin
			queue_tile(left, bottom, wd, ht, 0, 1'b1);
		end else if (cnt == 2) begin
			ph = ht / 2;
			queue_tile(left, bottom + ph, wd, ph, 0, 1'b0);
			queue_tile(left, bottom, wd, ph, 1, 1'b1);
		end else begin
			n = 1;
			while (n * n < cnt)
				n++;
			extra = n * n - cnt;
			extra_rows = extra / n;
			rows = n - extra_rows;
			last_len = n - (extra - extra_rows * n);
			pw = wd / n;
			ph = ht / rows;
			slide = (extra > 0) ? (wd / 2 - (last_len * pw) / 2) : 0;
			k = 0;
			// top row first; only the bottom row is short and slid
			for (int i = 0; i < rows; i++) begin
				len = (i == rows - 1) ? last_len : n;
				sx = (i == rows - 1) ? slide : 0;
				for (int j = 0; j < len; j++) begin
					queue_tile(left + pw * j + sx, bottom + ph * (rows - i - 1), pw, ph,
						k, k == cnt - 1);
					k++;
				end
			end
		end
	endfunction

	task automatic report_tile(input string what, input tile_t want, input tile_t got);
		fail_cnt++;
		if (fail_cnt <= REPORT_LIMIT) begin
			$display("%s: exp x=%0d y=%0d w=%0d h=%0d idx=%0d last=%0b",
				what, want.x, want.y, want.w, want.h, want.idx, want.last);
			$display("    got x=%0d y=%0d w=%0d h=%0d idx=%0d last=%0b",
				got.x, got.y, got.w, got.h, got.idx, got.last);
		end
	endtask

	// Take requests into the predictor and check tiles in one place so the
	// order of the two is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (start && !busy) begin
				idle_cycles = 0;
				if (want_pending)
					tiles_due = {tiles_due, want_tile};
				else
					layout_tiles(vp_x, vp_y, vp_width, vp_height, viewport_count);
			end
			if (tile_valid) begin
				idle_cycles = 0;
				seen_tile = '{tile_x, tile_y, tile_width, tile_height, tile_index, last_tile};
				if (tiles_due.size() == 0) begin
					report_tile("unexpected tile", '0, seen_tile);
				end else begin
					due_tile = tiles_due.pop_front();
					if (seen_tile.x !== due_tile.x || seen_tile.y !== due_tile.y ||
							seen_tile.w !== due_tile.w || seen_tile.h !== due_tile.h ||
							seen_tile.idx !== due_tile.idx || seen_tile.last !== due_tile.last)
						report_tile("tile mismatch", due_tile, seen_tile);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Present one word and hold it until taken; returns on the next falling edge.
	task automatic issue(input request_t r);
		vp_x = r.x;
		vp_y = r.y;
		vp_width = r.w;
		vp_height = r.h;
		viewport_count = r.vc;
		want_pending = r.has_want;
		want_tile = r.want;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start = 1'b0;
			// scramble the fields while start is low
			vp_x = XY_W'($urandom);
			vp_y = XY_W'($urandom);
			vp_width = DIM_W'($urandom);
			vp_height = DIM_W'($urandom);
			viewport_count = VC_W'($urandom);
			repeat (cycles) @(negedge clk);
		end
	endtask

	initial begin
		request_t req;
		int pick;
		int gap;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			issue(plan[i]);
			idle_for((i % 4 == 3) ? $urandom_range(1, 40) : 0);
		end

		// drain before the random part
		start = 1'b0;
		while (tiles_due.size() != 0)
			@(negedge clk);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 25 == 12) begin
				start = 1'b0;
				while (tiles_due.size() != 0)
					@(negedge clk);
			end
			req = '0;
			req.x = XY_W'($urandom);
			req.y = XY_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				req.w = DIM_W'($urandom);
				req.h = DIM_W'($urandom);
			end else if (pick < 80) begin
				req.w = DIM_W'($urandom_range(0, 64));
				req.h = DIM_W'($urandom_range(0, 64));
			end else begin
				req.w = DIM_W'($urandom_range(32700, 32767));
				req.h = DIM_W'($urandom_range(32700, 32767));
			end
			pick = $urandom_range(0, 99);
			if (pick < 5)
				req.vc = '0;
			else if (pick < 82)
				req.vc = VC_W'($urandom_range(1, MAX_TILES));
			else
				req.vc = VC_W'($urandom_range(MAX_TILES + 1, 31));
			issue(req);
			// every third block of thirty requests runs back to back
			if ((i / 30) % 3 == 1) begin
				gap = 0;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					gap = 0;
				else if (pick < 85)
					gap = $urandom_range(1, 4);
				else
					gap = $urandom_range(20, 70);
			end
			idle_for(gap);
		end
		start = 1'b0;

		while (tiles_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		fail_cnt += tiles_due.size();
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
